FILE: rtl/core/lobm_pkg.sv
// Package: shared constants and types for the order book matcher.
`default_nettype none
package lobm_pkg;
  localparam int ORDER_SLOTS_DEF = 32;
  localparam int PRICE_BITS_DEF = 32;
  localparam int QTY_BITS_DEF = 32;
  localparam int FIELD_BITS = 32;

  localparam logic [1:0] OP_LIMIT = 2'd0;
  localparam logic [1:0] OP_MARKET = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic SIDE_BUY = 1'b0;
  localparam logic KIND_EXEC = 1'b0;
  localparam logic KIND_DONE = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/core/lobm_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module lobm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/limit_order_book_matcher_unit.sv
// Top level: price-time priority order book with a sequential slot scan.
//
// Input channel (in_valid/in_ready) takes one order or cancel transaction;
// output channel (out_valid/out_ready) returns zero or more executions and
// then one completion transaction with last set.
// Every input is handled alone: in_ready is low until its completion is taken.
// Each fill needs one scan over all slots through the slot RAM, one slot per
// cycle, then a registered read and a close of the scan, then an update
// step in S_FILL. Completion needs one more scan for the best bid and ask
// and the output step in S_OUT; resting a remainder needs a free-slot scan,
// which stops at the first free slot.
// Reset clears all slot valid bits and the arrival counter at once; no
// clearing pass is needed. A stalled receiver holds the output transaction
// and the scan simply waits.
`default_nettype none
module limit_order_book_matcher_unit #(
  parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_BITS = lobm_pkg::PRICE_BITS_DEF,
  parameter int QTY_BITS = lobm_pkg::QTY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic        side,
  input  wire logic [31:0] order_id,
  input  wire logic [31:0] price,
  input  wire logic [31:0] quantity,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [31:0]      buyer_id,
  output logic [31:0]      seller_id,
  output logic [31:0]      fill_price,
  output logic [31:0]      fill_quantity,
  output logic [31:0]      remaining_quantity,
  output logic [31:0]      best_bid_price,
  output logic [31:0]      best_ask_price,
  output logic [1:0]       status,
  output logic             last
);
  localparam int IW = $clog2(ORDER_SLOTS);
  localparam int RW = 1 + PRICE_BITS + QTY_BITS + 64;
  localparam int PB = PRICE_BITS;
  localparam int QB = QTY_BITS;
  localparam int FB = lobm_pkg::FIELD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FILL, S_FREE, S_BEST, S_OUT
  } state_t;
  typedef enum logic [1:0] {SC_MATCH, SC_CANCEL, SC_FREE, SC_BEST} scan_t;

  state_t state;
  scan_t scan;
  logic [ORDER_SLOTS-1:0] slot_valid;
  logic [31:0] arrival_counter;
  logic [1:0] op_r;
  logic side_r;
  logic [31:0] id_r;
  logic [PB-1:0] price_r;
  logic [QB-1:0] rem;
  logic [1:0] st_r;
  logic [IW:0] idx;
  logic rd_v1;
  logic [IW-1:0] rd_i1;
  logic found;
  logic [IW-1:0] best_i;
  logic [PB-1:0] best_p;
  logic [QB-1:0] best_q;
  logic [31:0] best_id, best_arr;
  logic bid_any, ask_any;
  logic [PB-1:0] bid_p, ask_p;

  logic ram_we;
  logic [IW-1:0] ram_addr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic r_side;
  logic [PB-1:0] r_price;
  logic [QB-1:0] r_qty;
  logic [31:0] r_id, r_arr;

  assign {r_side, r_price, r_qty, r_id, r_arr} = ram_rdata;

  lobm_ram #(.WIDTH(RW), .DEPTH(ORDER_SLOTS)) u_slots (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [QB-1:0] fill_x;
  assign fill_x = (rem < best_q) ? rem : best_q;

  // write port: fill update or insert
  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx[IW-1:0];
    ram_wdata = {side_r, price_r, rem, id_r, arrival_counter};
    if (state == S_FILL && out_ready) begin
      ram_we = 1'b1;
      ram_addr = best_i;
      ram_wdata = {~side_r, best_p, best_q - fill_x, best_id, best_arr};
    end else if (state == S_FREE) begin
      ram_we = 1'b1;
      ram_addr = best_i;
    end else if (state == S_SCAN) begin
      ram_addr = idx[IW-1:0];
    end
  end

  // per-slot compare (the shared unit)
  logic v_ok, cand;
  always_comb begin
    v_ok = rd_v1 && slot_valid[rd_i1];
    cand = 1'b0;
    unique case (scan)
      SC_MATCH: begin
        if (v_ok && r_side != side_r &&
            (op_r == lobm_pkg::OP_MARKET ||
             (side_r == lobm_pkg::SIDE_BUY ? r_price <= price_r : r_price >= price_r))) begin
          if (!found) cand = 1'b1;
          else if (r_price != best_p)
            cand = (side_r == lobm_pkg::SIDE_BUY) ? r_price < best_p : r_price > best_p;
          else cand = r_arr < best_arr;
        end
      end
      SC_CANCEL: begin
        if (v_ok && r_side == side_r && r_price == price_r && r_id == id_r)
          cand = !found || r_arr < best_arr;
      end
      SC_FREE: cand = 1'b0;
      SC_BEST: cand = 1'b0;
      default: cand = 1'b0;
    endcase
  end

  logic scan_done;
  assign scan_done = !rd_v1 && idx == ORDER_SLOTS[IW:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scan <= SC_BEST;
      slot_valid <= '0;
      arrival_counter <= '0;
      out_valid <= 1'b0;
      rd_v1 <= 1'b0;
    end else begin
      rd_v1 <= 1'b0;
      rd_i1 <= idx[IW-1:0];
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_r <= opcode;
            side_r <= side;
            id_r <= order_id;
            price_r <= PB'(price);
            rem <= QB'(quantity);
            st_r <= lobm_pkg::ST_OK;
            idx <= '0;
            found <= 1'b0;
            if (opcode == lobm_pkg::OP_CANCEL) begin
              scan <= SC_CANCEL; state <= S_SCAN;
            end else if ((opcode == lobm_pkg::OP_LIMIT || opcode == lobm_pkg::OP_MARKET)
                         && QB'(quantity) != '0) begin
              scan <= SC_MATCH; state <= S_SCAN;
            end else begin
              scan <= SC_BEST; state <= S_SCAN;
              rem <= '0;
              bid_any <= 1'b0; ask_any <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (scan == SC_BEST || scan == SC_FREE) begin
            if (idx != ORDER_SLOTS[IW:0]) begin
              if (scan == SC_FREE && !slot_valid[idx[IW-1:0]]) begin
                best_i <= idx[IW-1:0];
                state <= S_FREE;
              end else begin
                rd_v1 <= (scan == SC_BEST);
                idx <= idx + (IW+1)'(1);
              end
            end else if (scan == SC_FREE) begin
              st_r <= lobm_pkg::ST_FULL;
              scan <= SC_BEST; idx <= '0; bid_any <= 1'b0; ask_any <= 1'b0;
            end else if (!rd_v1) begin
              state <= S_OUT;
            end
            if (scan == SC_BEST && rd_v1 && slot_valid[rd_i1]) begin
              if (r_side == lobm_pkg::SIDE_BUY) begin
                if (!bid_any || r_price > bid_p) bid_p <= r_price;
                bid_any <= 1'b1;
              end else begin
                if (!ask_any || r_price < ask_p) ask_p <= r_price;
                ask_any <= 1'b1;
              end
            end
          end else begin
            if (idx != ORDER_SLOTS[IW:0]) begin
              rd_v1 <= 1'b1;
              idx <= idx + (IW+1)'(1);
            end
            if (cand) begin
              found <= 1'b1;
              best_i <= rd_i1; best_p <= r_price; best_q <= r_qty;
              best_id <= r_id; best_arr <= r_arr;
            end
            if (scan_done) begin
              idx <= '0;
              if (scan == SC_CANCEL) begin
                if (found) slot_valid[best_i] <= 1'b0;
                else st_r <= lobm_pkg::ST_NOT_FOUND;
                rem <= '0;
                scan <= SC_BEST; bid_any <= 1'b0; ask_any <= 1'b0;
              end else if (found) begin
                state <= S_FILL;
                out_valid <= 1'b1;
                kind <= lobm_pkg::KIND_EXEC;
                buyer_id <= side_r == lobm_pkg::SIDE_BUY ? id_r : best_id;
                seller_id <= side_r == lobm_pkg::SIDE_BUY ? best_id : id_r;
                fill_price <= FB'(best_p);
                fill_quantity <= FB'(fill_x);
                remaining_quantity <= '0;
                best_bid_price <= '0;
                best_ask_price <= '0;
                status <= lobm_pkg::ST_OK;
                last <= 1'b0;
              end else if (op_r == lobm_pkg::OP_LIMIT) begin
                scan <= SC_FREE;
              end else begin
                scan <= SC_BEST; bid_any <= 1'b0; ask_any <= 1'b0;
              end
            end
          end
        end
        S_FILL: begin
          if (out_ready) begin
            rem <= rem - fill_x;
            if (best_q == fill_x) slot_valid[best_i] <= 1'b0;
            found <= 1'b0;
            idx <= '0;
            state <= S_SCAN;
            if (rem == fill_x) begin
              scan <= SC_BEST; bid_any <= 1'b0; ask_any <= 1'b0;
            end
          end
        end
        S_FREE: begin
          slot_valid[best_i] <= 1'b1;
          arrival_counter <= arrival_counter + 32'd1;
          scan <= SC_BEST; idx <= '0; bid_any <= 1'b0; ask_any <= 1'b0;
          state <= S_SCAN;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            kind <= lobm_pkg::KIND_DONE;
            buyer_id <= '0; seller_id <= '0;
            fill_price <= '0; fill_quantity <= '0;
            remaining_quantity <= FB'(rem);
            best_bid_price <= bid_any ? FB'(bid_p) : '0;
            best_ask_price <= ask_any ? FB'(ask_p) : '0;
            status <= st_r;
            last <= 1'b1;
          end else if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

`ifndef ASSERT_OFF
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == kind)) else $error("last mismatch");
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |-> fill_x != '0) else $error("zero fill");
`endif
endmodule
`default_nettype wire
